### rtl/core/nearest_light_selector_defines.svh
// ----------------------------------------------------------------------------
// nearest light selector assertion macros
// shared concurrent assertion wrappers for the selector rtl
// ----------------------------------------------------------------------------
`ifndef NEAREST_LIGHT_SELECTOR_DEFINES_SVH
`define NEAREST_LIGHT_SELECTOR_DEFINES_SVH

// same-cycle implication, held off while reset is high
`define NLS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off while reset is high
`define NLS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/nls_pkg.sv
// ----------------------------------------------------------------------------
// nls_pkg
// sizes, codes, types and helpers shared by the nearest light selector
// ----------------------------------------------------------------------------
package nls_pkg;

   localparam int MAX_LIGHTS = 16;
   localparam int MAX_PICKS  = 8;
   localparam int COORD_BITS = 24;

   localparam int ID_W       = 8;
   localparam int KIND_W     = 2;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int LIMIT_W    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   localparam int IDX_W      = $clog2(MAX_LIGHTS);
   localparam int CNT_W      = $clog2(MAX_LIGHTS + 1);
   localparam int PICK_CNT_W = $clog2(MAX_PICKS + 1);

   // distance arithmetic: |a-b| needs one extra bit, sum of three squares two more
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int SUM_W  = SQ_W + 2;
   localparam int DIST_W = (SUM_W > 64) ? 64 : SUM_W;
   localparam logic [SUM_W-1:0] DIST_MAX = SUM_W'({DIST_W{1'b1}});

   // the three distance stages of the pipe, used to size the query drain
   localparam int DIST_LAT  = 3;
   localparam int DRAIN_CYC = MAX_PICKS + DIST_LAT + 2;
   localparam int DRAIN_W   = $clog2(DRAIN_CYC + 1);

   localparam logic [LIMIT_W-1:0] SPOT_LIMIT_RST  = LIMIT_W'(1);
   localparam logic [LIMIT_W-1:0] POINT_LIMIT_RST = LIMIT_W'(4);

   localparam logic [CSR_IDX_W-1:0] CSR_SPOT_LIMIT  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_LIMIT = CSR_IDX_W'(1);

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DIR   = 2'd0,
      KIND_POINT = 2'd1,
      KIND_SPOT  = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_DUP  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_QFEED,
      S_QDRAIN,
      S_EMIT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]              id;
      logic [KIND_W-1:0]            kind;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } entry_type;

   typedef struct packed {
      logic              valid;
      logic [DIST_W-1:0] range_sq;
      logic [IDX_W-1:0]  idx;
      logic [ID_W-1:0]   id;
   } pick_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } chain_ctl_type;

   // table index breaks distance ties, so earlier entries win
   function automatic logic key_less(input pick_type a, input pick_type b);
      return {a.range_sq, a.idx} < {b.range_sq, b.idx};
   endfunction

   function automatic logic [DIST_W-1:0] sat_dist(input logic [SUM_W-1:0] s);
      return (s > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(s);
   endfunction

endpackage

### rtl/core/nls_req_if.sv
// ----------------------------------------------------------------------------
// nls_req_if
// request channel: table operation, light id, type and position
// ----------------------------------------------------------------------------
interface nls_req_if import nls_pkg::*; ();

   logic                         valid;
   logic                         ready;
   logic [OP_W-1:0]              op;
   logic [ID_W-1:0]              light_id;
   logic [KIND_W-1:0]            light_type;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic signed [COORD_BITS-1:0] pos_z;

   modport source (
      output valid, op, light_id, light_type, pos_x, pos_y, pos_z,
      input  ready
   );

   modport sink (
      input  valid, op, light_id, light_type, pos_x, pos_y, pos_z,
      output ready
   );

endinterface

### rtl/core/nls_rsp_if.sv
// ----------------------------------------------------------------------------
// nls_rsp_if
// response channel: one beat per selected light or per finished operation
// ----------------------------------------------------------------------------
interface nls_rsp_if import nls_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     found_id;
   logic                found;
   logic                last;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, found_id, found, last, status,
      input  ready
   );

   modport sink (
      input  valid, found_id, found, last, status,
      output ready
   );

endinterface

### rtl/core/nearest_light_selector.sv
// ----------------------------------------------------------------------------
// nearest_light_selector
// light table with add, remove, clear and nearest-of-type query
// ----------------------------------------------------------------------------
// Works on one request at a time; ready is high while no request is in work,
// also when a response beat still waits. The table is a memory read one entry
// per cycle, so add, remove and query walk the stored lights in turn; a remove
// then moves each later light down one place, a clear only resets the count,
// and a query fills and settles the pick chain before its beats go out. Query
// results come out nearest first; equal distances go to the light added earlier.
`include "nearest_light_selector_defines.svh"

module nearest_light_selector import nls_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   nls_req_if.sink               req_chan,
   nls_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [CNT_W-1:0]      CNT_ONE  = CNT_W'(1);
   localparam logic [IDX_W-1:0]      IDX_ONE  = IDX_W'(1);
   localparam logic [PICK_CNT_W-1:0] PICK_ONE = PICK_CNT_W'(1);

   state_type                    state_ff, state_in;
   logic [OP_W-1:0]              op_ff;
   logic [ID_W-1:0]              id_ff;
   logic [KIND_W-1:0]            kind_ff;
   logic signed [COORD_BITS-1:0] x_ff, y_ff, z_ff;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [CNT_W-1:0]             issue_ff, issue_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]             rd_idx_ff;
   entry_type                    rd_data_ff;
   logic                         hit_ff, hit_in;
   logic [IDX_W-1:0]             hit_idx_ff, hit_idx_in;
   logic [DRAIN_W-1:0]           drain_ff, drain_in;
   logic [PICK_CNT_W-1:0]        lim_ff, lim_in;
   logic [PICK_CNT_W-1:0]        emit_ff, emit_in;
   status_type                   status_ff, status_in;
   logic [LIMIT_W-1:0]           spot_limit_ff, point_limit_ff;

   logic                         rsp_vld_ff;
   logic [ID_W-1:0]              rsp_id_ff;
   logic                         rsp_found_ff;
   logic                         rsp_last_ff;
   status_type                   rsp_status_ff;

   logic                         req_accept;
   logic                         rsp_free;
   logic                         rsp_load;
   logic [ID_W-1:0]              ld_id;
   logic                         ld_found;
   logic                         ld_last;
   status_type                   ld_status;
   logic                         emit_last;

   logic                         mem_we;
   logic [IDX_W-1:0]             mem_waddr;
   entry_type                    mem_wdata;
   entry_type                    table_mem [MAX_LIGHTS];

   chain_ctl_type                chain_ctl;
   logic                         dist_vld;
   pick_type                     cand_pick;
   pick_type                     head_pick, second_pick;

   function automatic logic [PICK_CNT_W-1:0] sat_limit(input logic [LIMIT_W-1:0] l);
      return (int'(l) > MAX_PICKS) ? PICK_CNT_W'(MAX_PICKS) : PICK_CNT_W'(l);
   endfunction

   function automatic logic [PICK_CNT_W-1:0] query_limit(
      input logic [KIND_W-1:0]  kind,
      input logic [LIMIT_W-1:0] spot_lim,
      input logic [LIMIT_W-1:0] point_lim
   );
      logic [PICK_CNT_W-1:0] r;
      case (kind)
         KIND_POINT: r = sat_limit(point_lim);
         KIND_SPOT:  r = sat_limit(spot_lim);
         default:    r = '0;
      endcase
      return r;
   endfunction

   assign req_accept     = req_chan.valid && (state_ff == S_IDLE);
   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_free       = !rsp_vld_ff || rsp_chan.ready;
   assign emit_last      = ((emit_ff + PICK_ONE) == lim_ff) || !second_pick.valid;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      issue_in   = issue_ff;
      rd_vld_in  = 1'b0;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      drain_in   = drain_ff;
      lim_in     = lim_ff;
      emit_in    = emit_ff;
      status_in  = status_ff;
      mem_we     = 1'b0;
      mem_waddr  = cnt_ff[IDX_W-1:0];
      mem_wdata.id   = id_ff;
      mem_wdata.kind = kind_ff;
      mem_wdata.x    = x_ff;
      mem_wdata.y    = y_ff;
      mem_wdata.z    = z_ff;
      chain_ctl  = '0;
      rsp_load   = 1'b0;
      ld_id      = '0;
      ld_found   = 1'b0;
      ld_last    = 1'b1;
      ld_status  = ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               issue_in  = '0;
               hit_in    = 1'b0;
               status_in = ST_OK;
               case (req_chan.op)
                  OP_ADD, OP_REMOVE: begin
                     state_in = S_SCAN;
                  end
                  OP_CLEAR: begin
                     cnt_in   = '0;
                     state_in = S_RESP;
                  end
                  OP_QUERY: begin
                     lim_in = query_limit(req_chan.light_type, spot_limit_ff, point_limit_ff);
                     if (lim_in == '0) begin
                        state_in = S_RESP;
                     end else begin
                        chain_ctl.clear = 1'b1;
                        state_in        = S_QFEED;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (issue_ff < cnt_ff) begin
               rd_vld_in = 1'b1;
               issue_in  = issue_ff + CNT_ONE;
            end
            if (rd_vld_ff && (rd_data_ff.id == id_ff) && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = rd_idx_ff;
            end
            if ((issue_ff == cnt_ff) && !rd_vld_ff) begin
               if (op_ff == OP_ADD) begin
                  state_in = S_RESP;
                  if (hit_ff) begin
                     status_in = ST_DUP;
                  end else if (cnt_ff == CNT_W'(MAX_LIGHTS)) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_we = 1'b1;
                     cnt_in = cnt_ff + CNT_ONE;
                  end
               end else if (hit_ff) begin
                  issue_in = CNT_W'(hit_idx_ff) + CNT_ONE;
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_RESP;
               end
            end
         end

         S_SHIFT: begin
            // close the gap: entry j+1 moves down to j
            if (issue_ff < cnt_ff) begin
               rd_vld_in = 1'b1;
               issue_in  = issue_ff + CNT_ONE;
            end
            if (rd_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = rd_idx_ff - IDX_ONE;
               mem_wdata = rd_data_ff;
            end
            if ((issue_ff == cnt_ff) && !rd_vld_ff) begin
               cnt_in   = cnt_ff - CNT_ONE;
               state_in = S_RESP;
            end
         end

         S_QFEED: begin
            if (issue_ff < cnt_ff) begin
               rd_vld_in = 1'b1;
               issue_in  = issue_ff + CNT_ONE;
            end else begin
               drain_in = DRAIN_W'(DRAIN_CYC);
               state_in = S_QDRAIN;
            end
         end

         S_QDRAIN: begin
            if (drain_ff == '0) begin
               emit_in  = '0;
               state_in = S_EMIT;
            end else begin
               drain_in = drain_ff - DRAIN_W'(1);
            end
         end

         S_EMIT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               if (head_pick.valid) begin
                  ld_found        = 1'b1;
                  ld_id           = head_pick.id;
                  ld_last         = emit_last;
                  chain_ctl.shift = 1'b1;
                  emit_in         = emit_ff + PICK_ONE;
                  if (emit_last) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_RESP: begin
            if (rsp_free) begin
               rsp_load  = 1'b1;
               ld_status = status_ff;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cnt_ff         <= '0;
         issue_ff       <= '0;
         rd_vld_ff      <= 1'b0;
         hit_ff         <= 1'b0;
         hit_idx_ff     <= '0;
         drain_ff       <= '0;
         lim_ff         <= '0;
         emit_ff        <= '0;
         status_ff      <= ST_OK;
         spot_limit_ff  <= SPOT_LIMIT_RST;
         point_limit_ff <= POINT_LIMIT_RST;
         rsp_vld_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         issue_ff   <= issue_in;
         rd_vld_ff  <= rd_vld_in;
         hit_ff     <= hit_in;
         hit_idx_ff <= hit_idx_in;
         drain_ff   <= drain_in;
         lim_ff     <= lim_in;
         emit_ff    <= emit_in;
         status_ff  <= status_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SPOT_LIMIT:  spot_limit_ff  <= csr_wdata;
               CSR_POINT_LIMIT: point_limit_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_chan.op;
         id_ff   <= req_chan.light_id;
         kind_ff <= req_chan.light_type;
         x_ff    <= req_chan.pos_x;
         y_ff    <= req_chan.pos_y;
         z_ff    <= req_chan.pos_z;
      end
      if (rsp_load) begin
         rsp_id_ff     <= ld_id;
         rsp_found_ff  <= ld_found;
         rsp_last_ff   <= ld_last;
         rsp_status_ff <= ld_status;
      end
   end

   // light table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[issue_ff[IDX_W-1:0]];
      rd_idx_ff  <= issue_ff[IDX_W-1:0];
   end

   assign dist_vld = rd_vld_ff && (op_ff == OP_QUERY) && (rd_data_ff.kind == kind_ff);

   nls_dist_pipe u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (dist_vld),
      .in_entry (rd_data_ff),
      .in_idx   (rd_idx_ff),
      .qx       (x_ff),
      .qy       (y_ff),
      .qz       (z_ff),
      .out_pick (cand_pick)
   );

   nls_pick_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .ctl     (chain_ctl),
      .in_pick (cand_pick),
      .head    (head_pick),
      .second  (second_pick)
   );

   assign rsp_chan.valid    = rsp_vld_ff;
   assign rsp_chan.found_id = rsp_id_ff;
   assign rsp_chan.found    = rsp_found_ff;
   assign rsp_chan.last     = rsp_last_ff;
   assign rsp_chan.status   = rsp_status_ff;

   `NLS_ASSERT_NOW(a_cnt_range, clock, reset, 1'b1,
      cnt_ff <= CNT_W'(MAX_LIGHTS), "light count beyond table size")
   `NLS_ASSERT_NOW(a_miss_is_last, clock, reset, rsp_vld_ff && !rsp_found_ff,
      rsp_last_ff && (rsp_id_ff == '0), "empty beat not final or carries an id")
   `NLS_ASSERT_NOW(a_error_no_pick, clock, reset, rsp_vld_ff && (rsp_status_ff != ST_OK),
      !rsp_found_ff, "error status on a pick beat")
   `NLS_ASSERT_NOW(a_emit_bound, clock, reset, state_ff == S_EMIT,
      emit_ff < lim_ff, "more picks than the limit")

endmodule

### rtl/core/nls_dist_pipe.sv
// ----------------------------------------------------------------------------
// nls_dist_pipe
// three-stage squared euclidean distance between a table entry and the query
// ----------------------------------------------------------------------------
module nls_dist_pipe import nls_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  entry_type                    in_entry,
   input  logic [IDX_W-1:0]             in_idx,
   input  logic signed [COORD_BITS-1:0] qx,
   input  logic signed [COORD_BITS-1:0] qy,
   input  logic signed [COORD_BITS-1:0] qz,
   output pick_type                     out_pick
);

   logic                vld1_ff, vld2_ff, vld3_ff;
   logic [IDX_W-1:0]    idx1_ff, idx2_ff;
   logic [ID_W-1:0]     id1_ff, id2_ff;
   logic [DIFF_W-1:0]   adx_ff, ady_ff, adz_ff;
   logic [DIFF_W-1:0]   adx_in, ady_in, adz_in;
   logic [SQ_W-1:0]     sqx_ff, sqy_ff, sqz_ff;
   logic [SUM_W-1:0]    sum_in;
   pick_type            pick_ff, pick_in;

   function automatic logic [DIFF_W-1:0] abs_diff(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      logic [DIFF_W-1:0] d;
      d = DIFF_W'(a) - DIFF_W'(b);
      return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
   endfunction

   always_comb begin
      adx_in = abs_diff(in_entry.x, qx);
      ady_in = abs_diff(in_entry.y, qy);
      adz_in = abs_diff(in_entry.z, qz);
      sum_in = SUM_W'(sqx_ff) + SUM_W'(sqy_ff) + SUM_W'(sqz_ff);
      pick_in.valid    = vld2_ff;
      pick_in.range_sq = sat_dist(sum_in);
      pick_in.idx      = idx2_ff;
      pick_in.id       = id2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
      idx1_ff <= in_idx;
      id1_ff  <= in_entry.id;
      adx_ff  <= adx_in;
      ady_ff  <= ady_in;
      adz_ff  <= adz_in;
      idx2_ff <= idx1_ff;
      id2_ff  <= id1_ff;
      sqx_ff  <= SQ_W'(adx_ff) * SQ_W'(adx_ff);
      sqy_ff  <= SQ_W'(ady_ff) * SQ_W'(ady_ff);
      sqz_ff  <= SQ_W'(adz_ff) * SQ_W'(adz_ff);
      pick_ff <= pick_in;
   end

   always_comb begin
      out_pick       = pick_ff;
      out_pick.valid = vld3_ff;
   end

endmodule

### rtl/core/nls_pick_cell.sv
// ----------------------------------------------------------------------------
// nls_pick_cell
// one slot of the sorted pick chain: keeps the smaller key, hands on the other
// ----------------------------------------------------------------------------
module nls_pick_cell import nls_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  chain_ctl_type ctl,
   input  pick_type      in_pick,
   input  pick_type      right_held,
   output pick_type      held,
   output pick_type      pass
);

   pick_type held_ff, held_in;
   pick_type pass_ff, pass_in;

   always_comb begin
      held_in = held_ff;
      pass_in = in_pick;
      if (ctl.clear) begin
         held_in = '0;
         pass_in = '0;
      end else if (ctl.shift) begin
         // unload toward the head, one slot per beat
         held_in = right_held;
         pass_in = '0;
      end else if (in_pick.valid && (!held_ff.valid || key_less(in_pick, held_ff))) begin
         held_in = in_pick;
         pass_in = held_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         pass_ff <= '0;
      end else begin
         held_ff <= held_in;
         pass_ff <= pass_in;
      end
   end

   assign held = held_ff;
   assign pass = pass_ff;

endmodule

### rtl/core/nls_pick_chain.sv
// ----------------------------------------------------------------------------
// nls_pick_chain
// row of pick cells holding the nearest candidates in ascending key order
// ----------------------------------------------------------------------------
`include "nearest_light_selector_defines.svh"

module nls_pick_chain import nls_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  chain_ctl_type ctl,
   input  pick_type      in_pick,
   output pick_type      head,
   output pick_type      second
);

   pick_type held_row [MAX_PICKS+1];
   pick_type left_row [MAX_PICKS];
   pick_type pass_row [MAX_PICKS];

   assign held_row[MAX_PICKS] = '0;
   assign left_row[0]         = in_pick;

   for (genvar k = 0; k < MAX_PICKS; k++) begin : g_cell
      if (k > 0) begin : g_link
         assign left_row[k] = pass_row[k-1];
      end
      nls_pick_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .in_pick    (left_row[k]),
         .right_held (held_row[k+1]),
         .held       (held_row[k]),
         .pass       (pass_row[k])
      );
   end

   assign head   = held_row[0];
   assign second = held_row[1];

   for (genvar k = 0; k < MAX_PICKS - 1; k++) begin : g_order
      `NLS_ASSERT_NOW(a_sorted, clock, reset, held_row[k+1].valid, held_row[k].valid && key_less(held_row[k], held_row[k+1]), "pick chain out of order")
   end

   `NLS_ASSERT_NEXT(a_shift_moves, clock, reset, ctl.shift && !ctl.clear, held_row[0] == $past(held_row[1]), "unload did not advance the chain")
   `NLS_ASSERT_NOW(a_drop_when_full, clock, reset, pass_row[MAX_PICKS-1].valid, held_row[MAX_PICKS-1].valid, "candidate dropped from a chain that is not full")

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Runs light table operations and nearest-light queries through the selector.
// Valid and ready gaps are random on both sides. A table predictor keeps its
// own copy of the lights and the limits, and every response beat is checked
// against it field by field.
// ----------------------------------------------------------------------------
module testbench;
   import nls_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 270;
   localparam int SETTLE_CYCLES  = 40;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef struct {
      op_type                       op;
      logic [ID_W-1:0]              light_id;
      logic [KIND_W-1:0]            light_type;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
   } light_op_type;

   typedef struct {
      logic [ID_W-1:0]     found_id;
      logic                found;
      logic                last;
      logic [STATUS_W-1:0] status;
   } light_beat_type;

   // predicted light table and the response beats still owed by the block
   class light_scoreboard;
      light_op_type       stored[$];
      logic [LIMIT_W-1:0] spot_lim;
      logic [LIMIT_W-1:0] point_lim;
      light_beat_type     awaited[$];
      int                 errors;

      function new();
         spot_lim  = SPOT_LIMIT_RST;
         point_lim = POINT_LIMIT_RST;
         errors    = 0;
      endfunction

      function void set_limit(logic [CSR_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
         if (idx == CSR_SPOT_LIMIT) begin
            spot_lim = val;
         end else begin
            point_lim = val;
         end
      endfunction

      function void push_done(status_type st);
         light_beat_type b;
         b.found_id = '0;
         b.found    = 1'b0;
         b.last     = 1'b1;
         b.status   = st;
         awaited.insert(awaited.size(), b);
      endfunction

      function longint dist_sq(light_op_type a, light_op_type b);
         longint dx;
         longint dy;
         longint dz;
         dx = longint'(a.pos_x) - longint'(b.pos_x);
         dy = longint'(a.pos_y) - longint'(b.pos_y);
         dz = longint'(a.pos_z) - longint'(b.pos_z);
         return dx * dx + dy * dy + dz * dz;
      endfunction

      function void note_request(light_op_type r);
         int             hit;
         int unsigned    lim;
         int             picks;
         int             best;
         bit             taken[MAX_LIGHTS];
         longint         range_sq[MAX_LIGHTS];
         light_beat_type b;
         hit = -1;
         foreach (stored[i]) begin
            if (hit < 0 && stored[i].light_id == r.light_id) hit = i;
         end
         case (r.op)
            OP_ADD: begin
               // duplicate check wins over the full check
               if (hit >= 0) push_done(ST_DUP);
               else if (stored.size() >= MAX_LIGHTS) push_done(ST_FULL);
               else begin
                  stored.insert(stored.size(), r);
                  push_done(ST_OK);
               end
            end
            OP_REMOVE: begin
               if (hit >= 0) stored.delete(hit);
               push_done(ST_OK);
            end
            OP_CLEAR: begin
               stored.delete();
               push_done(ST_OK);
            end
            default: begin
               if (r.light_type == KIND_POINT) lim = point_lim;
               else if (r.light_type == KIND_SPOT) lim = spot_lim;
               else lim = 0;
               if (lim > MAX_PICKS) lim = MAX_PICKS;
               foreach (stored[i]) begin
                  taken[i]    = 1'b0;
                  range_sq[i] = dist_sq(stored[i], r);
               end
               picks = 0;
               for (int p = 0; p < lim; p++) begin
                  best = -1;
                  // strict compare keeps the earlier light on a tie
                  foreach (stored[i]) begin
                     if (!taken[i] && stored[i].light_type == r.light_type &&
                         (best < 0 || range_sq[i] < range_sq[best])) best = i;
                  end
                  if (best < 0) break;
                  taken[best] = 1'b1;
                  b.found_id  = stored[best].light_id;
                  b.found     = 1'b1;
                  b.last      = 1'b0;
                  b.status    = ST_OK;
                  awaited.insert(awaited.size(), b);
                  picks++;
               end
               if (picks == 0) push_done(ST_OK);
               else awaited[awaited.size()-1].last = 1'b1;
            end
         endcase
      endfunction

      function void check_beat(light_beat_type got);
         light_beat_type want;
         if (awaited.size() == 0) begin
            $error("unexpected beat: found_id %0d found %0b last %0b status %0d",
                   got.found_id, got.found, got.last, got.status);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.found_id !== want.found_id) begin
            $error("found_id mismatch: expected %0d, actual %0d", want.found_id, got.found_id);
            errors++;
         end
         if (got.found !== want.found) begin
            $error("found mismatch: expected %0b, actual %0b", want.found, got.found);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, got.last);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   nls_req_if req_chan();
   nls_rsp_if rsp_chan();

   light_scoreboard board;
   bit              send_calm;
   bit              recv_calm;
   int              quiet_cycles = 0;
   int              sent_items = 0;
   logic [ID_W-1:0] id_base;

   nearest_light_selector u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // both channels and the register port seen at the rising edge
   always @(posedge clock) begin
      light_op_type   seen;
      light_beat_type beat;
      if (!reset) begin
         if (csr_we) board.set_limit(csr_index, csr_wdata);
         if (req_chan.valid && req_chan.ready) begin
            seen.op         = op_type'(req_chan.op);
            seen.light_id   = req_chan.light_id;
            seen.light_type = req_chan.light_type;
            seen.pos_x      = req_chan.pos_x;
            seen.pos_y      = req_chan.pos_y;
            seen.pos_z      = req_chan.pos_z;
            board.note_request(seen);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            beat.found_id = rsp_chan.found_id;
            beat.found    = rsp_chan.found;
            beat.last     = rsp_chan.last;
            beat.status   = rsp_chan.status;
            board.check_beat(beat);
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             csr_we) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // response side: random stall before each beat
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         stall = recv_calm ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   task automatic send_op(input op_type op, input logic [ID_W-1:0] id,
                          input logic [KIND_W-1:0] kind,
                          input logic signed [COORD_BITS-1:0] x,
                          input logic signed [COORD_BITS-1:0] y,
                          input logic signed [COORD_BITS-1:0] z);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.light_id   <= id;
      req_chan.light_type <= kind;
      req_chan.pos_x      <= x;
      req_chan.pos_y      <= y;
      req_chan.pos_z      <= z;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      sent_items++;
   endtask

   // hold requests until every owed beat has come back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (board.awaited.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_limits(input logic [LIMIT_W-1:0] spot, input logic [LIMIT_W-1:0] point);
      csr_we    <= 1'b1;
      csr_index <= CSR_SPOT_LIMIT;
      csr_wdata <= spot;
      @(posedge clock);
      @(negedge clock);
      csr_index <= CSR_POINT_LIMIT;
      csr_wdata <= point;
      @(posedge clock);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic signed [COORD_BITS-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return COORD_MIN;
         1: return COORD_MAX;
         // clustered near the origin so equal distances show up
         2, 3: return COORD_BITS'(int'($urandom_range(0, 16)) - 8);
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] rand_kind();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return KIND_DIR;
      if (pick == 1) return KIND_UNUSED;
      if (pick < 6) return KIND_POINT;
      return KIND_SPOT;
   endfunction

   function automatic logic [LIMIT_W-1:0] rand_limit();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return LIMIT_W'(MAX_PICKS);
         2: return '1;
         default: return LIMIT_W'($urandom_range(0, 15));
      endcase
   endfunction

   initial begin
      int  steps;
      int  stop_at;
      bit  first;
      board               = new();
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_SPOT_LIMIT;
      csr_wdata           = '0;
      req_chan.valid      = 1'b0;
      req_chan.op         = OP_ADD;
      req_chan.light_id   = '0;
      req_chan.light_type = KIND_DIR;
      req_chan.pos_x      = '0;
      req_chan.pos_y      = '0;
      req_chan.pos_z      = '0;
      send_calm           = 1'b0;
      recv_calm           = 1'b0;
      id_base             = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset limits, extremes, ties, duplicates, odd types
      send_op(OP_QUERY, 8'd0, KIND_POINT, 0, 0, 0);
      send_op(OP_ADD, 8'd0, KIND_POINT, 0, 0, 0);
      send_op(OP_ADD, 8'd255, KIND_POINT, COORD_MAX, COORD_MAX, COORD_MAX);
      send_op(OP_ADD, 8'd10, KIND_POINT, COORD_MIN, COORD_MIN, COORD_MIN);
      send_op(OP_ADD, 8'd20, KIND_SPOT, 3, 0, 0);
      send_op(OP_ADD, 8'd21, KIND_SPOT, 0, 3, 0);
      send_op(OP_ADD, 8'd30, KIND_DIR, 1, 1, 1);
      send_op(OP_ADD, 8'd40, KIND_UNUSED, 1, 1, 1);
      send_op(OP_ADD, 8'd0, KIND_SPOT, 5, 5, 5);
      send_op(OP_ADD, 8'd50, KIND_POINT, 2, -2, 1);
      send_op(OP_QUERY, 8'd0, KIND_POINT, 0, 0, 0);
      send_op(OP_QUERY, 8'd0, KIND_SPOT, 0, 0, 0);
      send_op(OP_QUERY, 8'd0, KIND_DIR, 1, 1, 1);
      send_op(OP_QUERY, 8'd0, KIND_UNUSED, 1, 1, 1);
      send_op(OP_QUERY, 8'd0, KIND_POINT, COORD_MIN, COORD_MIN, COORD_MIN);
      send_op(OP_REMOVE, 8'd99, KIND_DIR, 0, 0, 0);
      send_op(OP_REMOVE, 8'd20, KIND_DIR, 0, 0, 0);
      send_op(OP_QUERY, 8'd0, KIND_SPOT, 0, 0, 0);
      send_op(OP_CLEAR, 8'd0, KIND_DIR, 0, 0, 0);
      send_op(OP_QUERY, 8'd0, KIND_POINT, 0, 0, 0);
      send_op(OP_REMOVE, 8'd0, KIND_DIR, 0, 0, 0);

      stop_at = sent_items + RANDOM_ITEMS;
      first   = 1'b1;
      while (sent_items < stop_at) begin
         wait_drained();
         if (first) set_limits('1, '1);
         else set_limits(rand_limit(), rand_limit());
         send_calm = ($urandom_range(0, 3) == 0);
         recv_calm = ($urandom_range(0, 3) == 0);
         if (first || $urandom_range(0, 3) == 0) begin
            // fill past capacity with distinct ids, then repeat one
            id_base = ID_W'($urandom);
            send_op(OP_CLEAR, ID_W'($urandom), KIND_W'($urandom), rand_coord(),
                    rand_coord(), rand_coord());
            for (int i = 0; i <= MAX_LIGHTS; i++) begin
               send_op(OP_ADD, ID_W'(id_base + i), rand_kind(), rand_coord(),
                       rand_coord(), rand_coord());
            end
            send_op(OP_ADD, id_base, rand_kind(), rand_coord(), rand_coord(), rand_coord());
         end else if ($urandom_range(0, 1) == 0) begin
            send_op(OP_CLEAR, ID_W'($urandom), KIND_W'($urandom), rand_coord(),
                    rand_coord(), rand_coord());
         end
         first = 1'b0;
         steps = $urandom_range(8, 30);
         repeat (steps) begin
            case ($urandom_range(0, 9))
               0, 1, 2: send_op(OP_ADD, ID_W'(id_base + $urandom_range(0, 23)), rand_kind(),
                                rand_coord(), rand_coord(), rand_coord());
               3: send_op(OP_REMOVE, ID_W'(id_base + $urandom_range(0, 23)),
                          KIND_W'($urandom), rand_coord(), rand_coord(), rand_coord());
               4: send_op(op_type'($urandom_range(0, 3)), ID_W'($urandom), KIND_W'($urandom),
                          COORD_BITS'($urandom), COORD_BITS'($urandom),
                          COORD_BITS'($urandom));
               default: send_op(OP_QUERY, ID_W'($urandom), rand_kind(), rand_coord(),
                                rand_coord(), rand_coord());
            endcase
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.awaited.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/nls_pkg.sv
rtl/core/nls_req_if.sv
rtl/core/nls_rsp_if.sv
rtl/core/nls_dist_pipe.sv
rtl/core/nls_pick_cell.sv
rtl/core/nls_pick_chain.sv
rtl/core/nearest_light_selector.sv
tb/testbench.sv
